>>> rtl/wmms_pkg.sv
`default_nettype none

package wmms_pkg;

  // window geometry
  localparam int WINDOW_LEN  = 16;
  localparam int SAMPLE_BITS = 24;
  localparam int MEAN_SHIFT  = 4;

  localparam int PTR_BITS = $clog2(WINDOW_LEN);
  localparam int CNT_BITS = $clog2(WINDOW_LEN + 1);
  localparam int SUM_BITS = SAMPLE_BITS + PTR_BITS;
  localparam int SYM_BITS = SAMPLE_BITS + 1;

  // working widths for the mean and the interval arithmetic
  localparam int EXT_BITS  = (SUM_BITS > SAMPLE_BITS + 2) ? SUM_BITS : SAMPLE_BITS + 2;
  localparam int DIFF_BITS = SAMPLE_BITS + 2;

  // saturation limits
  localparam logic signed [EXT_BITS-1:0] MEAN_HI =
    EXT_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [EXT_BITS-1:0] MEAN_LO = -MEAN_HI - EXT_BITS'(1);
  localparam logic signed [DIFF_BITS-1:0] SYM_HI =
    DIFF_BITS'((64'sd1 <<< (SYM_BITS - 1)) - 64'sd1);
  localparam logic signed [DIFF_BITS-1:0] SYM_LO = -SYM_HI - DIFF_BITS'(1);

  localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(WINDOW_LEN);
  localparam logic [PTR_BITS-1:0] LAST_PTR   = PTR_BITS'(WINDOW_LEN - 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SYM_BITS-1:0]    sym_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MEAN,
    ST_DIFF,
    ST_LOAD
  } wmms_state_t;

  // controller to datapath
  typedef struct packed {
    logic                wr_en;
    logic [PTR_BITS-1:0] wr_addr;
    logic                rd_en;
    logic [PTR_BITS-1:0] rd_addr;
    logic                scan_first;
    logic                scan_acc;
    logic                calc_mean;
    logic                calc_diff;
    logic                load_out;
  } wmms_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } wmms_stat_t;

endpackage

`default_nettype wire

>>> rtl/wmms_if.sv
`default_nettype none

// sample channel
interface wmms_in_if
  import wmms_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// result channel
interface wmms_out_if
  import wmms_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t window_min;
  sample_t window_max;
  sample_t window_mean;
  sym_t    sym_low;
  sym_t    sym_high;

  modport source (output valid, output window_min, output window_max, output window_mean,
                  output sym_low, output sym_high, input ready);
  modport sink (input valid, input window_min, input window_max, input window_mean,
                input sym_low, input sym_high, output ready);
endinterface

`default_nettype wire

>>> rtl/wmms_ram.sv
`default_nettype none

module wmms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/wmms_ctrl.sv
`default_nettype none

module wmms_ctrl
  import wmms_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire wmms_stat_t stat,
  output wmms_cmd_t       cmd
);

  wmms_state_t         state, state_next;
  logic [CNT_BITS-1:0] fill_count, fill_count_next;
  logic [PTR_BITS-1:0] write_pointer, write_pointer_next;
  logic [CNT_BITS-1:0] scan_idx, scan_idx_next;
  logic                accept;

  assign accept = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && fill_count_next == FULL_COUNT) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx == FULL_COUNT) begin
          state_next = ST_MEAN;
        end
      end
      ST_MEAN: state_next = ST_DIFF;
      ST_DIFF: state_next = ST_LOAD;
      ST_LOAD: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // pointer, fill and scan counters
  always_comb begin
    fill_count_next    = fill_count;
    write_pointer_next = write_pointer;
    scan_idx_next      = '0;
    if (accept) begin
      if (fill_count != FULL_COUNT) begin
        fill_count_next = fill_count + CNT_BITS'(1);
      end
      write_pointer_next = (write_pointer == LAST_PTR) ? '0 : write_pointer + PTR_BITS'(1);
    end
    if (state == ST_SCAN) begin
      scan_idx_next = scan_idx + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fill_count    <= '0;
      write_pointer <= '0;
      scan_idx      <= '0;
    end else begin
      state         <= state_next;
      fill_count    <= fill_count_next;
      write_pointer <= write_pointer_next;
      scan_idx      <= scan_idx_next;
    end
  end

  // outputs
  always_comb begin
    in_ready       = (state == ST_IDLE);
    cmd            = '0;
    cmd.wr_en      = accept;
    cmd.wr_addr    = write_pointer;
    cmd.rd_addr    = scan_idx[PTR_BITS-1:0];
    case (state)
      ST_SCAN: begin
        cmd.rd_en      = (scan_idx != FULL_COUNT);
        cmd.scan_acc   = (scan_idx != '0);
        cmd.scan_first = (scan_idx == CNT_BITS'(1));
      end
      ST_MEAN: cmd.calc_mean = 1'b1;
      ST_DIFF: cmd.calc_diff = 1'b1;
      ST_LOAD: cmd.load_out  = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/wmms_dp.sv
`default_nettype none

module wmms_dp
  import wmms_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire sample_t   sample,
  input  wire wmms_cmd_t cmd,
  output wmms_stat_t     stat,
  wmms_out_if.source     results
);

  logic [SAMPLE_BITS-1:0]        rd_raw;
  sample_t                       rd_val;
  sample_t                       mn, mx, mean;
  logic signed [SUM_BITS-1:0]    sum;
  logic signed [DIFF_BITS-1:0]   ldiff, rdiff;
  logic signed [EXT_BITS-1:0]    mean_full;
  logic signed [DIFF_BITS-1:0]   mean_ext, lo_full, hi_full, lo_sat, hi_sat;
  logic                          out_valid;

  // window storage
  wmms_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_LEN)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (cmd.wr_addr),
    .wdata (sample),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (rd_raw)
  );

  assign rd_val = sample_t'(rd_raw);

  // running min, max and sum over the scan
  always_ff @(posedge clk) begin
    if (cmd.scan_acc) begin
      if (cmd.scan_first) begin
        mn  <= rd_val;
        mx  <= rd_val;
        sum <= SUM_BITS'(rd_val);
      end else begin
        if (rd_val < mn) begin
          mn <= rd_val;
        end
        if (rd_val > mx) begin
          mx <= rd_val;
        end
        sum <= sum + SUM_BITS'(rd_val);
      end
    end
  end

  // floor mean with saturation
  assign mean_full = EXT_BITS'(sum) >>> MEAN_SHIFT;

  always_ff @(posedge clk) begin
    if (cmd.calc_mean) begin
      if (mean_full > MEAN_HI) begin
        mean <= MEAN_HI[SAMPLE_BITS-1:0];
      end else if (mean_full < MEAN_LO) begin
        mean <= MEAN_LO[SAMPLE_BITS-1:0];
      end else begin
        mean <= mean_full[SAMPLE_BITS-1:0];
      end
    end
  end

  // distances from the mean to each end
  assign mean_ext = DIFF_BITS'(mean);

  always_ff @(posedge clk) begin
    if (cmd.calc_diff) begin
      ldiff <= mean_ext - DIFF_BITS'(mn);
      rdiff <= DIFF_BITS'(mx) - mean_ext;
    end
  end

  // widen the closer side, then saturate
  always_comb begin
    if (ldiff < rdiff) begin
      lo_full = mean_ext - rdiff;
      hi_full = DIFF_BITS'(mx);
    end else begin
      lo_full = DIFF_BITS'(mn);
      hi_full = mean_ext + ldiff;
    end
    lo_sat = (lo_full > SYM_HI) ? SYM_HI : ((lo_full < SYM_LO) ? SYM_LO : lo_full);
    hi_sat = (hi_full > SYM_HI) ? SYM_HI : ((hi_full < SYM_LO) ? SYM_LO : hi_full);
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      results.window_min  <= mn;
      results.window_max  <= mx;
      results.window_mean <= mean;
      results.sym_low     <= lo_sat[SYM_BITS-1:0];
      results.sym_high    <= hi_sat[SYM_BITS-1:0];
    end
  end

  assign results.valid = out_valid;
  assign stat.out_free = !out_valid || results.ready;

endmodule

`default_nettype wire

>>> rtl/window_minmax_mean_symmetric.sv
`default_nettype none

// channel   dir  payload
// samples   in   sample (24 bit signed, Q12.12)
// results   out  window_min, window_max, window_mean (24 bit), sym_low, sym_high (25 bit)
//
// an accepted word is written to the window in its accept cycle; until the window holds
// 16 samples, the block is ready again on the next cycle and gives no result
// with a full window, a word goes through the scan over the single window memory
// read port, then mean, distance and output load
// the output register lets a new sample be taken while a result waits; the load stalls
// until the register is free. synchronous reset empties the window and output register

module window_minmax_mean_symmetric
  import wmms_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  wmms_in_if.sink     samples,
  wmms_out_if.source  results
);

  wmms_cmd_t  cmd;
  wmms_stat_t stat;

  // sequencer
  wmms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // window memory and arithmetic
  wmms_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .sample  (samples.sample),
    .cmd     (cmd),
    .stat    (stat),
    .results (results)
  );

endmodule

`default_nettype wire
